/* rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define QDEC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qdec assertion failed");

// next-cycle implication, disabled during reset
`define QDEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qdec assertion failed");

`endif

/* rtl/qdec_pkg.sv */
// types and constants of the debounced quadrature decoder
package qdec_pkg;

    typedef enum logic [1:0] {
        TURN_NONE  = 2'd0,
        TURN_RIGHT = 2'd1,
        TURN_LEFT  = 2'd2
    } turn_t;

    typedef enum logic {
        OP_FAST = 1'b0,
        OP_SLOW = 1'b1
    } opcode_t;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_TICKS   = 3'd0,
        CFG_EDGE_TIMEOUT     = 3'd1,
        CFG_FAST_DECAY_EXTRA = 3'd2,
        CFG_LOWER_LIMIT      = 3'd3,
        CFG_UPPER_LIMIT      = 3'd4
    } cfg_index_t;

    localparam logic [7:0]        DEBOUNCE_TICKS_RST   = 8'd5;
    localparam logic [7:0]        EDGE_TIMEOUT_RST     = 8'd10;
    localparam logic [7:0]        FAST_DECAY_EXTRA_RST = 8'd2;
    localparam logic signed [7:0] LOWER_LIMIT_RST      = -8'sd4;
    localparam logic [6:0]        UPPER_LIMIT_RST      = 7'd4;

    typedef struct packed {
        logic [7:0]        debounce_ticks;
        logic [7:0]        edge_timeout;
        logic [7:0]        fast_decay_extra;
        logic signed [7:0] lower_limit;
        logic [6:0]        upper_limit;
    } qdec_cfg_t;

    typedef struct packed {
        logic              level_a;
        logic              level_b;
        logic              accepted_a;
        logic              accepted_b;
        logic [7:0]        settle_a;
        logic [7:0]        settle_b;
        logic [7:0]        idle_timer;
        logic              fast_mode;
        logic signed [7:0] position;
        logic signed [7:0] last_position;
        logic [7:0]        detents;
    } qdec_state_t;

    typedef struct packed {
        turn_t             turn;
        logic [7:0]        count_out;
        logic signed [7:0] position_out;
        logic              missed_edge;
    } qdec_result_t;

endpackage

/* rtl/qdec_if.sv */
// sample and result channel interfaces
interface qdec_sample_if;
    import qdec_pkg::*;
    logic valid;
    logic ready;
    logic opcode;
    logic raw_a;
    logic raw_b;
    modport source (output valid, opcode, raw_a, raw_b, input ready);
    modport sink (input valid, opcode, raw_a, raw_b, output ready);
endinterface

interface qdec_result_if;
    import qdec_pkg::*;
    logic              valid;
    logic              ready;
    turn_t             turn;
    logic [7:0]        count_out;
    logic signed [7:0] position_out;
    logic              missed_edge;
    modport source (output valid, turn, count_out, position_out, missed_edge, input ready);
    modport sink (input valid, turn, count_out, position_out, missed_edge, output ready);
endinterface

/* rtl/qdec_step.sv */
// next-state and result logic for one sample or timeout tick
module qdec_step (
    input  qdec_pkg::qdec_cfg_t    cfg,
    input  qdec_pkg::qdec_state_t  state,
    input  logic                   opcode,
    input  logic                   raw_a,
    input  logic                   raw_b,
    output qdec_pkg::qdec_state_t  state_next,
    output qdec_pkg::qdec_result_t result
);
    import qdec_pkg::*;

    typedef struct packed {
        logic       level;
        logic [7:0] settle;
        logic       changed;
    } deb_t;

    function automatic deb_t debounce(input logic raw, input logic level,
                                      input logic [7:0] settle, input logic accepted,
                                      input logic [7:0] ticks);
        deb_t d;
        d.level   = level;
        d.settle  = settle;
        d.changed = 1'b0;
        if (level != raw)
        begin
            d.level  = raw;
            d.settle = ticks;
        end
        else if (settle != 8'd0)
        begin
            d.settle  = settle - 8'd1;
            d.changed = (d.settle == 8'd0) && (accepted != level);
        end
        return d;
    endfunction

    deb_t              deb_a;
    deb_t              deb_b;
    logic              da;
    logic              db;
    logic              cw;
    logic signed [7:0] pos;
    logic [7:0]        timer;

    assign deb_a = debounce(raw_a, state.level_a, state.settle_a, state.accepted_a,
                            cfg.debounce_ticks);
    assign deb_b = debounce(raw_b, state.level_b, state.settle_b, state.accepted_b,
                            cfg.debounce_ticks);
    // decode compares the accepted levels with the freshly sampled ones
    assign da = state.accepted_a ^ deb_a.level;
    assign db = state.accepted_b ^ deb_b.level;
    assign cw = da ? (deb_a.level != state.accepted_b) : (deb_b.level == state.accepted_a);

    always_comb
    begin
        state_next          = state;
        result.turn         = TURN_NONE;
        result.missed_edge  = 1'b0;
        pos                 = state.position;
        timer               = state.idle_timer;
        if (opcode == OP_FAST)
        begin
            state_next.level_a  = deb_a.level;
            state_next.level_b  = deb_b.level;
            state_next.settle_a = deb_a.settle;
            state_next.settle_b = deb_b.settle;
            if (deb_a.changed || deb_b.changed)
            begin
                state_next.idle_timer = cfg.edge_timeout;
                if (da && db)
                begin
                    // missed edge: repeat the last direction
                    result.missed_edge   = 1'b1;
                    state_next.fast_mode = 1'b1;
                    if (state.last_position != 8'sd0)
                    begin
                        pos = state.last_position[7] ? pos - 8'sd1 : pos + 8'sd1;
                    end
                end
                else if (da || db)
                begin
                    pos = cw ? pos + 8'sd1 : pos - 8'sd1;
                end
                state_next.last_position = pos;
                if (pos == cfg.lower_limit)
                begin
                    pos                = 8'sd0;
                    state_next.detents = state.detents + 8'd1;
                    result.turn        = TURN_RIGHT;
                end
                else if (pos == $signed({1'b0, cfg.upper_limit}))
                begin
                    pos                = 8'sd0;
                    state_next.detents = state.detents - 8'd1;
                    result.turn        = TURN_LEFT;
                end
                if (deb_a.changed)
                begin
                    state_next.accepted_a = deb_a.level;
                end
                if (deb_b.changed)
                begin
                    state_next.accepted_b = deb_b.level;
                end
            end
        end
        else if (state.idle_timer != 8'd0)
        begin
            timer = state.idle_timer - 8'd1;
            if (state.fast_mode)
            begin
                timer = (timer > cfg.fast_decay_extra) ? timer - cfg.fast_decay_extra : 8'd0;
            end
            state_next.idle_timer = timer;
            if (timer == 8'd0)
            begin
                state_next.fast_mode = 1'b0;
                pos                  = 8'sd0;
            end
        end
        state_next.position = pos;
        result.count_out    = state_next.detents;
        result.position_out = pos;
    end

endmodule

/* rtl/qdec_out_buf.sv */
// two-entry result register with skid stage
module qdec_out_buf (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  qdec_pkg::qdec_result_t push_data,
    output logic                   space,
    qdec_result_if.source          result
);
    import qdec_pkg::*;

    logic         main_valid_reg;
    logic         main_valid_next;
    qdec_result_t main_reg;
    qdec_result_t main_next;
    logic         skid_valid_reg;
    logic         skid_valid_next;
    qdec_result_t skid_reg;
    qdec_result_t skid_next;
    logic         pop;

    assign space = !skid_valid_reg;
    assign pop   = main_valid_reg && result.ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_next       = main_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                main_next = push_data;
            end
            else
            begin
                main_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_next       = push_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_next       = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign result.valid        = main_valid_reg;
    assign result.turn         = main_reg.turn;
    assign result.count_out    = main_reg.count_out;
    assign result.position_out = main_reg.position_out;
    assign result.missed_edge  = main_reg.missed_edge;

endmodule

/* rtl/debounced_quadrature_decoder_core.sv */
// top level of the debounced quadrature decoder
// a result goes to the output buffer's main or skid register when its tick is taken
// throughput: one tick per cycle while the result buffer has space, state is updated in the cycle of the transaction
// a two-entry result buffer keeps ticks flowing while one result waits
// reset: levels, settle counters, detents and position clear, the idle timer and registers load their defaults
module debounced_quadrature_decoder_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [qdec_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    qdec_sample_if.sink                    sample,
    qdec_result_if.source                  result
);
    import qdec_pkg::*;

    qdec_cfg_t    cfg_reg;
    qdec_cfg_t    cfg_next;
    qdec_state_t  state_reg;
    qdec_state_t  state_next;
    qdec_state_t  step_state;
    qdec_result_t step_result;
    logic         accept;
    logic         space;

    assign sample.ready = space;
    assign accept       = sample.valid && space;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE_TICKS:   cfg_next.debounce_ticks   = cfg_data;
                CFG_EDGE_TIMEOUT:     cfg_next.edge_timeout     = cfg_data;
                CFG_FAST_DECAY_EXTRA: cfg_next.fast_decay_extra = cfg_data;
                CFG_LOWER_LIMIT:      cfg_next.lower_limit      = $signed(cfg_data);
                CFG_UPPER_LIMIT:      cfg_next.upper_limit      = cfg_data[6:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    qdec_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .opcode     (sample.opcode),
        .raw_a      (sample.raw_a),
        .raw_b      (sample.raw_b),
        .state_next (step_state),
        .result     (step_result)
    );

    assign state_next = accept ? step_state : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks   <= DEBOUNCE_TICKS_RST;
            cfg_reg.edge_timeout     <= EDGE_TIMEOUT_RST;
            cfg_reg.fast_decay_extra <= FAST_DECAY_EXTRA_RST;
            cfg_reg.lower_limit      <= LOWER_LIMIT_RST;
            cfg_reg.upper_limit      <= UPPER_LIMIT_RST;
            state_reg.level_a        <= 1'b0;
            state_reg.level_b        <= 1'b0;
            state_reg.accepted_a     <= 1'b0;
            state_reg.accepted_b     <= 1'b0;
            state_reg.settle_a       <= 8'd0;
            state_reg.settle_b       <= 8'd0;
            state_reg.idle_timer     <= EDGE_TIMEOUT_RST;
            state_reg.fast_mode      <= 1'b0;
            state_reg.position       <= 8'sd0;
            state_reg.last_position  <= 8'sd0;
            state_reg.detents        <= 8'd0;
        end
        else
        begin
            cfg_reg   <= cfg_next;
            state_reg <= state_next;
        end
    end

    qdec_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (step_result),
        .space     (space),
        .result    (result)
    );

endmodule

/* rtl/qdec_checker.sv */
// port-level checker for the decoder core and its bind
`include "assert_macros.svh"

module qdec_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              res_valid,
    input logic              res_ready,
    input logic [1:0]        res_turn,
    input logic [7:0]        res_count,
    input logic signed [7:0] res_position,
    input logic              res_missed
);
    import qdec_pkg::*;

    // a turn only comes with the idle position
    `QDEC_ASSERT_IMPLY(a_turn_idle, clk, rst_n, res_valid && res_turn != TURN_NONE, res_position == 8'sd0)

    // only the none, right and left codes appear
    `QDEC_ASSERT_IMPLY(a_turn_code, clk, rst_n, res_valid, res_turn == TURN_NONE || res_turn == TURN_RIGHT || res_turn == TURN_LEFT)

    // a stalled result holds
    `QDEC_ASSERT_NEXT(a_result_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_turn) && $stable(res_count) && $stable(res_position) && $stable(res_missed))

endmodule

bind debounced_quadrature_decoder_core qdec_checker u_qdec_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .res_turn     (result.turn),
    .res_count    (result.count_out),
    .res_position (result.position_out),
    .res_missed   (result.missed_edge)
);

/* sim/tb.sv */
// self-checking testbench of the debounced quadrature decoder core
`timescale 1ns / 100ps

module tb;
    import qdec_pkg::*;

    // register index past the last register, writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    qdec_sample_if tick_ch ();
    qdec_result_if res_ch ();

    debounced_quadrature_decoder_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (tick_ch),
        .result    (res_ch)
    );

    // predicted decoder registers
    logic [7:0]        cfg_debounce;
    logic [7:0]        cfg_timeout;
    logic [7:0]        cfg_extra;
    logic signed [7:0] cfg_lower;
    logic [6:0]        cfg_upper;

    // predicted decoder state
    logic              lvl_a;
    logic              lvl_b;
    logic              acc_a;
    logic              acc_b;
    logic [7:0]        settle_a;
    logic [7:0]        settle_b;
    logic [7:0]        idle_timer;
    logic              fast_mode;
    logic signed [7:0] pos;
    logic signed [7:0] last_pos;
    logic [7:0]        detents;

    qdec_result_t pending_readings[$];
    int           mismatch_count;
    int           ticks_sent;
    int           send_idle_pct;
    int           stall_pct;
    logic         pin_a;
    logic         pin_b;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic void settle_channel(input logic raw, inout logic lvl,
                                           inout logic [7:0] cnt, input logic acc,
                                           output logic changed);
        changed = 1'b0;
        if (lvl != raw)
        begin
            lvl = raw;
            cnt = cfg_debounce;
        end
        else if (cnt != 8'd0)
        begin
            cnt = cnt - 8'd1;
            changed = (cnt == 8'd0) && (acc != lvl);
        end
    endfunction

    function automatic qdec_result_t decode_tick(input opcode_t op, input logic a,
                                                 input logic b);
        qdec_result_t r;
        logic         ch_a;
        logic         ch_b;
        logic         da;
        logic         db;
        logic         cw;
        logic         missed;
        r.turn = TURN_NONE;
        missed = 1'b0;
        if (op == OP_FAST)
        begin
            settle_channel(a, lvl_a, settle_a, acc_a, ch_a);
            settle_channel(b, lvl_b, settle_b, acc_b, ch_b);
            if (ch_a || ch_b)
            begin
                idle_timer = cfg_timeout;
                da = acc_a ^ lvl_a;
                db = acc_b ^ lvl_b;
                if (da && db)
                    missed = 1'b1;
                else if (da || db)
                begin
                    // gray order: clockwise when new a differs from old b, or when new b equals old a
                    cw = da ? (lvl_a != acc_b) : (lvl_b == acc_a);
                    pos = cw ? pos + 8'sd1 : pos - 8'sd1;
                end
                if (missed)
                begin
                    fast_mode = 1'b1;
                    if (last_pos > 8'sd0)
                        pos = pos + 8'sd1;
                    else if (last_pos < 8'sd0)
                        pos = pos - 8'sd1;
                end
                last_pos = pos;
                if (pos == cfg_lower)
                begin
                    pos = 8'sd0;
                    detents = detents + 8'd1;
                    r.turn = TURN_RIGHT;
                end
                else if (pos == $signed({1'b0, cfg_upper}))
                begin
                    pos = 8'sd0;
                    detents = detents - 8'd1;
                    r.turn = TURN_LEFT;
                end
                if (ch_a)
                    acc_a = lvl_a;
                if (ch_b)
                    acc_b = lvl_b;
            end
        end
        else if (idle_timer != 8'd0)
        begin
            idle_timer = idle_timer - 8'd1;
            if (fast_mode)
                idle_timer = (idle_timer > cfg_extra) ? idle_timer - cfg_extra : 8'd0;
            if (idle_timer == 8'd0)
            begin
                fast_mode = 1'b0;
                pos = 8'sd0;
            end
        end
        r.count_out = detents;
        r.position_out = pos;
        r.missed_edge = missed;
        return r;
    endfunction

    // result side: compare each transaction, then pick the next ready level
    initial
    begin : reading_check
        qdec_result_t exp_r;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
            begin
                if (pending_readings.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual turn %0d count %0d",
                             $time, res_ch.turn, res_ch.count_out);
                    mismatch_count++;
                end
                else
                begin
                    exp_r = pending_readings.pop_front();
                    if (res_ch.turn !== exp_r.turn)
                    begin
                        $display("%0t: turn mismatch, expected %0d, actual %0d",
                                 $time, exp_r.turn, res_ch.turn);
                        mismatch_count++;
                    end
                    if (res_ch.count_out !== exp_r.count_out)
                    begin
                        $display("%0t: count_out mismatch, expected %0d, actual %0d",
                                 $time, exp_r.count_out, res_ch.count_out);
                        mismatch_count++;
                    end
                    if (res_ch.position_out !== exp_r.position_out)
                    begin
                        $display("%0t: position_out mismatch, expected %0d, actual %0d",
                                 $time, exp_r.position_out, res_ch.position_out);
                        mismatch_count++;
                    end
                    if (res_ch.missed_edge !== exp_r.missed_edge)
                    begin
                        $display("%0t: missed_edge mismatch, expected %0d, actual %0d",
                                 $time, exp_r.missed_edge, res_ch.missed_edge);
                        mismatch_count++;
                    end
                end
            end
            res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic send_tick(input opcode_t op, input logic a, input logic b);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            tick_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        tick_ch.valid  <= 1'b1;
        tick_ch.opcode <= op;
        tick_ch.raw_a  <= a;
        tick_ch.raw_b  <= b;
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
        pending_readings.push_back(decode_tick(op, a, b));
        if (op == OP_FAST)
        begin
            pin_a = a;
            pin_b = b;
        end
        ticks_sent++;
    endtask

    task automatic hold_pins(input logic a, input logic b, input int n);
        repeat (n)
            send_tick(OP_FAST, a, b);
    endtask

    task automatic rotate(input bit cw, input int steps, input int hold);
        logic na;
        logic nb;
        repeat (steps)
        begin
            na = cw ? ~pin_b : pin_b;
            nb = cw ? pin_a : ~pin_a;
            hold_pins(na, nb, hold);
        end
    endtask

    task automatic slow_ticks(input int n);
        repeat (n)
            send_tick(OP_SLOW, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // let every outstanding transaction come back before touching registers
    task automatic drain_readings();
        tick_ch.valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (3)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_DEBOUNCE_TICKS:   cfg_debounce = data;
            CFG_EDGE_TIMEOUT:     cfg_timeout = data;
            CFG_FAST_DECAY_EXTRA: cfg_extra = data;
            CFG_LOWER_LIMIT:      cfg_lower = data;
            CFG_UPPER_LIMIT:      cfg_upper = data[6:0];
            default:              ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] deb, to, extra,
                              input logic signed [7:0] lo, input logic [6:0] up);
        write_reg(CFG_DEBOUNCE_TICKS, deb);
        write_reg(CFG_EDGE_TIMEOUT, to);
        write_reg(CFG_FAST_DECAY_EXTRA, extra);
        write_reg(CFG_LOWER_LIMIT, lo);
        write_reg(CFG_UPPER_LIMIT, {1'b0, up});
        cfg_we <= 1'b0;
    endtask

    task automatic test_directed_sequence();
        drain_readings();
        set_config(8'd1, EDGE_TIMEOUT_RST, FAST_DECAY_EXTRA_RST, LOWER_LIMIT_RST,
                   UPPER_LIMIT_RST);
        // four clockwise steps reach the upper limit, four back the lower one
        rotate(1'b1, 4, 2);
        rotate(1'b0, 4, 2);
        // both channels flip at once
        hold_pins(~pin_a, ~pin_b, 2);
        // glitch on a shorter than the debounce
        hold_pins(~pin_a, pin_b, 1);
        hold_pins(~pin_a, pin_b, 2);
        // fast decay down to expiry, then a tick on an expired timer
        slow_ticks(5);
    endtask

    task automatic test_register_extremes();
        drain_readings();
        // zero debounce never accepts a change
        set_config(8'd0, 8'd255, 8'd255, -8'sd127, 7'd127);
        rotate(1'b1, 3, 4);
        hold_pins(~pin_a, ~pin_b, 3);
        slow_ticks(3);
        drain_readings();
        set_config(8'd255, 8'd0, 8'd0, -8'sd1, 7'd1);
        rotate(1'b1, 1, 256);
        slow_ticks(2);
        drain_readings();
        set_config(8'd2, 8'd3, 8'd255, -8'sd2, 7'd2);
        @(posedge clk);
        write_reg(CFG_IDX_UNUSED, 8'd0);
        cfg_we <= 1'b0;
        rotate(1'b0, 1, 3);
        hold_pins(~pin_a, ~pin_b, 3);
        slow_ticks(2);
        rotate(1'b1, 3, 3);
        hold_pins(~pin_a, ~pin_b, 3);
        slow_ticks(1);
    endtask

    task automatic test_limit_match_and_wrap();
        drain_readings();
        // limits at zero match the idle position
        set_config(8'd1, 8'd2, 8'd1, 8'sd0, 7'd0);
        rotate(1'b1, 1, 2);
        rotate(1'b0, 1, 2);
        hold_pins(~pin_a, ~pin_b, 2);
        rotate(1'b0, 2, 2);
        slow_ticks(3);
        drain_readings();
        // walk past +127 so the position wraps onto the lower limit
        set_config(8'd1, 8'd255, 8'd0, -8'sd128, 7'd0);
        rotate(1'b1, 130, 2);
    endtask

    task automatic random_config();
        logic [7:0]        deb;
        logic [7:0]        to;
        logic [7:0]        extra;
        logic signed [7:0] lo;
        logic [6:0]        up;
        deb = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : $urandom_range(1, 3));
        to = 8'(($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 24));
        extra = 8'(($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 3));
        lo = 8'(0 - (($urandom_range(0, 9) == 0) ? $urandom_range(1, 127)
                                                   : $urandom_range(1, 6)));
        up = 7'(($urandom_range(0, 9) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 6));
        set_config(deb, to, extra, lo, up);
    endtask

    task automatic run_random_phase(input int idle_mode, input int n_ticks);
        int   start;
        int   act;
        int   hold;
        int   len;
        bit   cw;
        logic ha;
        logic hb;
        drain_readings();
        send_idle_pct = (idle_mode == 1) ? 61 : (idle_mode == 3) ? 30 : 0;
        stall_pct = (idle_mode == 2) ? 61 : (idle_mode == 3) ? 30 : 0;
        random_config();
        start = ticks_sent;
        cw = 1'($urandom_range(0, 1));
        while (ticks_sent - start < n_ticks)
        begin
            act = $urandom_range(0, 99);
            hold = cfg_debounce + 1 + $urandom_range(0, 1);
            if (act < 55)
            begin
                // mostly keep turning one way so the limits get reached
                if ($urandom_range(0, 4) == 0)
                    cw = ~cw;
                rotate(cw, 1, hold);
            end
            else if (act < 62)
                hold_pins(~pin_a, ~pin_b, hold);
            else if (act < 72)
            begin
                ha = pin_a;
                hb = pin_b;
                len = $urandom_range(1, (cfg_debounce == 8'd0) ? 1 : cfg_debounce);
                if ($urandom_range(0, 1))
                    hold_pins(~ha, hb, len);
                else
                    hold_pins(ha, ~hb, len);
                hold_pins(ha, hb, hold);
            end
            else if (act < 90)
                slow_ticks($urandom_range(1, 8));
            else
                repeat ($urandom_range(1, 4))
                    send_tick(opcode_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_random_traffic();
        for (int mode = 0; mode < 4; mode++)
            repeat (2)
                run_random_phase(mode, 20);
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_DEBOUNCE_TICKS;
        cfg_data = 8'd0;
        tick_ch.valid = 1'b0;
        tick_ch.opcode = OP_FAST;
        tick_ch.raw_a = 1'b0;
        tick_ch.raw_b = 1'b0;
        mismatch_count = 0;
        ticks_sent = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        pin_a = 1'b0;
        pin_b = 1'b0;
        cfg_debounce = DEBOUNCE_TICKS_RST;
        cfg_timeout = EDGE_TIMEOUT_RST;
        cfg_extra = FAST_DECAY_EXTRA_RST;
        cfg_lower = LOWER_LIMIT_RST;
        cfg_upper = UPPER_LIMIT_RST;
        lvl_a = 1'b0;
        lvl_b = 1'b0;
        acc_a = 1'b0;
        acc_b = 1'b0;
        settle_a = 8'd0;
        settle_b = 8'd0;
        idle_timer = EDGE_TIMEOUT_RST;
        fast_mode = 1'b0;
        pos = 8'sd0;
        last_pos = 8'sd0;
        detents = 8'd0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        test_directed_sequence();
        test_register_extremes();
        test_limit_match_and_wrap();
        test_random_traffic();
        drain_readings();
        repeat (4)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/qdec_pkg.sv
rtl/qdec_if.sv
rtl/qdec_step.sv
rtl/qdec_out_buf.sv
rtl/debounced_quadrature_decoder_core.sv
rtl/qdec_checker.sv
sim/tb.sv
